// ===== rtl/bmpu_pkg.sv =====
package bmpu_pkg;

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_PORT  = 2'd2;

  localparam logic [1:0] PST_NONE   = 2'd0;
  localparam logic [1:0] PST_1FFD   = 2'd1;
  localparam logic [1:0] PST_7FFD   = 2'd2;
  localparam logic [1:0] PST_LOCKED = 2'd3;

  localparam logic [15:0] PORT_DEC_MASK = 16'hf002;
  localparam logic [15:0] PORT_1FFD     = 16'h1000;

  localparam logic [2:0] SCREEN_NORMAL = 3'd5;
  localparam logic [2:0] SCREEN_SHADOW = 3'd7;

  localparam logic [3:0] ROM_BASE = 4'd8;
  localparam logic [3:0] BANK_S1  = 4'd5;
  localparam logic [3:0] BANK_S2  = 4'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] address;
    logic [7:0]  data;
  } in_t;

  typedef struct packed {
    logic [3:0]  bank;
    logic [13:0] offset;
    logic        write_enable;
    logic        contended;
    logic [2:0]  display_bank;
    logic        disk_motor;
    logic [1:0]  port_status;
    logic        paging_locked;
  } out_t;

  // paging state kept as the bits that matter
  typedef struct packed {
    logic [2:0] ram_sel;   // 7ffd[2:0]
    logic       rom_lo;    // 7ffd[4]
    logic       locked;    // 7ffd[5]
    logic [3:0] r1ffd;     // 1ffd[3:0]
    logic [2:0] screen;
  } state_t;

  function automatic logic [3:0] special_bank(input logic [1:0] cfg, input logic [1:0] slot);
    logic [3:0] b;
    b = 4'd0;
    unique case (cfg)
      2'd0: b = {2'b00, slot};
      2'd1: b = {2'b01, slot};
      2'd2: b = (slot == 2'd3) ? 4'd3 : {2'b01, slot};
      default: begin
        unique case (slot)
          2'd0: b = 4'd4;
          2'd1: b = 4'd7;
          2'd2: b = 4'd6;
          default: b = 4'd3;
        endcase
      end
    endcase
    return b;
  endfunction

  function automatic logic [3:0] slot_bank(input state_t st, input logic [1:0] slot);
    logic [3:0] b;
    b = 4'd0;
    if (st.r1ffd[0]) begin
      b = special_bank(st.r1ffd[2:1], slot);
    end else begin
      unique case (slot)
        2'd0: b = ROM_BASE | {2'b00, st.r1ffd[2], st.rom_lo};
        2'd1: b = BANK_S1;
        2'd2: b = BANK_S2;
        default: b = {1'b0, st.ram_sel};
      endcase
    end
    return b;
  endfunction

endpackage

// ===== rtl/bmpu_regs.sv =====
module bmpu_regs (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            upd,
  input  bmpu_pkg::state_t st_nxt,
  output bmpu_pkg::state_t st_r
);
  import bmpu_pkg::*;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.ram_sel <= '0;
      st_r.rom_lo  <= 1'b0;
      st_r.locked  <= 1'b0;
      st_r.r1ffd   <= '0;
      st_r.screen  <= SCREEN_NORMAL;
    end else if (upd) begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== rtl/bmpu_xlate.sv =====
module bmpu_xlate (
  input  bmpu_pkg::in_t    item,
  input  bmpu_pkg::state_t st,
  output bmpu_pkg::state_t st_nxt,
  output bmpu_pkg::out_t   res
);
  import bmpu_pkg::*;

  logic [1:0]  slot;
  logic [3:0]  bank;
  logic [15:0] dec;
  logic        sel_1ffd;
  logic        sel_7ffd;
  logic        is_mem;

  assign slot     = item.address[15:14];
  assign bank     = slot_bank(st, slot);
  assign dec      = item.address & PORT_DEC_MASK;
  assign sel_1ffd = (dec == PORT_1FFD);
  assign sel_7ffd = (dec[15:14] == 2'b01) && (dec[11:0] == 12'd0);
  assign is_mem   = (item.req_type == REQ_READ) || (item.req_type == REQ_WRITE);

  always_comb begin
    st_nxt = st;
    res = '0;
    if (is_mem) begin
      res.bank   = bank;
      res.offset = item.address[13:0];
      res.write_enable = (item.req_type == REQ_WRITE) && !bank[3] &&
                         (st.r1ffd[0] || (slot != 2'd0));
      res.contended = (slot == 2'd1) || ((slot == 2'd3) && bank[0]);
    end else if (item.req_type == REQ_PORT) begin
      if (sel_1ffd) begin
        st_nxt.r1ffd    = item.data[3:0];
        res.port_status = PST_1FFD;
      end else if (sel_7ffd) begin
        if (st.locked) begin
          res.port_status = PST_LOCKED;
        end else begin
          st_nxt.ram_sel  = item.data[2:0];
          st_nxt.rom_lo   = item.data[4];
          st_nxt.locked   = item.data[5];
          st_nxt.screen   = item.data[3] ? SCREEN_SHADOW : SCREEN_NORMAL;
          res.port_status = PST_7FFD;
        end
      end
    end
    res.display_bank  = st_nxt.screen;
    res.disk_motor    = st_nxt.r1ffd[3];
    res.paging_locked = st_nxt.locked;
  end

endmodule

// ===== rtl/banked_memory_paging_unit.sv =====
// Banked memory paging unit.
// Input channel (in_valid/in_ready/in_data) carries one bus request per beat:
// a memory read, a memory write or a port write. Output channel
// (out_valid/out_ready/out_data) returns one result beat per request, in
// order: physical bank, offset, write enable, contention flag, display bank,
// disk motor bit, port decode status and paging lock.
// A request is captured in an input register, translated combinationally
// against the current paging registers, and lands in the output register.
// One request is taken every cycle while results drain.
// Port writes update the paging registers as they pass through the
// translate stage, so later requests see the new map.
// Reset (rst_n low, synchronous) empties both stages and restores normal
// paging: ROM bank 8, banks 5 and 2, RAM bank 0, display bank 5, unlocked.
// When the receiver stalls, the output beat holds, the held request stays
// in the input register and in_ready drops until out_ready returns.
module banked_memory_paging_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  bmpu_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output bmpu_pkg::out_t  out_data
);
  import bmpu_pkg::*;

  logic   s1_valid_r;
  in_t    s1_item_r;
  logic   out_valid_r;
  out_t   out_data_r;
  logic   s1_adv;
  state_t st_r;
  state_t st_nxt;
  out_t   res;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
  end

  bmpu_xlate u_xlate (
    .item   (s1_item_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  bmpu_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd    (s1_adv),
    .st_nxt (st_nxt),
    .st_r   (st_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
